// ===== src/rsse_pkg.sv =====
// Package: shared types, constants and helper functions for the radial sine surface evaluator.
package rsse_pkg;

  localparam int ROOT_W   = 20;
  localparam int RAD_W    = 40;
  localparam int REM_W    = 23;
  localparam int SQ_SIDE_W = 32;
  localparam int CD_SIDE_W = 16 + 16 + ROOT_W + 32 + 32;
  localparam int RED_STEPS = 5;
  localparam int ANG_W    = 34;
  localparam int IDX_W    = 8;

  localparam logic [36:0] TWO_PI_Q28 = 37'd1686629713;
  localparam logic [36:0] PI_Q28 = 37'd843314857;
  localparam logic signed [37:0] WRAP_Q28 = 38'sd26986075408;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic signed [ANG_W-1:0] ATAN_Q30 [0:31] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128,
    34'sd64, 34'sd32, 34'sd16, 34'sd8,
    34'sd4, 34'sd2, 34'sd1, 34'sd0
  };

  typedef enum logic [IDX_W-1:0] {
    REG_AMPLITUDE = 8'd0,
    REG_FREQUENCY = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                    valid;
    logic                    neg;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/rsse_in_if.sv =====
// Interface: input channel carrying one parameter point per beat.
interface rsse_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] param_u;
  logic signed [15:0] param_v;
  modport source(output valid, output param_u, output param_v, input ready);
  modport sink(input valid, input param_u, input param_v, output ready);
endinterface

// ===== src/rsse_out_if.sv =====
// Interface: output channel carrying one evaluated surface point per beat.
interface rsse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        radius;
  logic signed [31:0] du_z;
  logic signed [31:0] dv_z;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  modport source(output valid, output pos_x, output pos_y, output pos_z, output radius,
                 output du_z, output dv_z, output normal_x, output normal_y, input ready);
  modport sink(input valid, input pos_x, input pos_y, input pos_z, input radius,
               input du_z, input dv_z, input normal_x, input normal_y, output ready);
endinterface

// ===== src/rsse_cfg_if.sv =====
// Interface: configuration write channel with register index and data.
interface rsse_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/rsse_sqrt_cell.sv =====
// Square root cell: one result bit of the digit-by-digit integer square root.
module rsse_sqrt_cell #(
  parameter int SIDE_W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  rsse_pkg::sqrt_t       din,
  input  logic [SIDE_W-1:0]     side_in,
  output rsse_pkg::sqrt_t       dout,
  output logic [SIDE_W-1:0]     side_out
);

  logic [rsse_pkg::REM_W-1:0] remx;
  logic [rsse_pkg::REM_W-1:0] trial;
  logic                       take;

  assign remx  = {din.rem[rsse_pkg::REM_W-3:0], din.n[rsse_pkg::RAD_W-1 -: 2]};
  assign trial = rsse_pkg::REM_W'({din.root, 2'b01});
  assign take  = remx >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
    if (adv) begin
      dout.n    <= {din.n[rsse_pkg::RAD_W-3:0], 2'b00};
      dout.rem  <= take ? remx - trial : remx;
      dout.root <= {din.root[rsse_pkg::ROOT_W-2:0], take};
      side_out  <= side_in;
    end
  end

endmodule

// ===== src/rsse_cordic_cell.sv =====
// CORDIC cell: one rotation-mode micro-rotation with a fixed shift and angle.
module rsse_cordic_cell #(
  parameter int IDX    = 0,
  parameter int SIDE_W = 116
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  rsse_pkg::cordic_t     din,
  input  logic [SIDE_W-1:0]     side_in,
  output rsse_pkg::cordic_t     dout,
  output logic [SIDE_W-1:0]     side_out
);

  logic signed [rsse_pkg::ANG_W-1:0] dx;
  logic signed [rsse_pkg::ANG_W-1:0] dy;
  logic signed [rsse_pkg::ANG_W-1:0] ang;

  assign dx  = din.y >>> IDX;
  assign dy  = din.x >>> IDX;
  assign ang = rsse_pkg::ATAN_Q30[IDX];

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
    if (adv) begin
      dout.neg <= din.neg;
      if (!din.z[rsse_pkg::ANG_W-1]) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - ang;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + ang;
      end
      side_out <= side_in;
    end
  end

endmodule

// ===== src/radial_sine_surface_eval.sv =====
// Top level: pipelined radial sine surface evaluator built from square root and CORDIC cells.
// Stages: input, r squared, square root, phase, reduction, fold, CORDIC, products, output.
// Throughput: one beat per cycle; the whole pipeline holds only while the output beat waits.
// Cost per point is set by the 20-cell square root chain and the CORDIC_STAGES-cell rotator.
// Reset (rst, synchronous) clears every valid flag and loads amplitude 1.5 and frequency 0.5.
// Configuration writes are taken in any cycle; the a*b product is registered from the stored values.
module radial_sine_surface_eval #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk,
  input  logic          rst,
  rsse_cfg_if.sink      cfg,
  rsse_in_if.sink       sample,
  rsse_out_if.source    result
);

  localparam int SQW = rsse_pkg::SQ_SIDE_W;
  localparam int CDW = rsse_pkg::CD_SIDE_W;
  localparam int RW  = rsse_pkg::ROOT_W;
  localparam int NRED = rsse_pkg::RED_STEPS;

  logic               adv;
  logic signed [15:0] amp;
  logic signed [15:0] freq;
  logic signed [31:0] ab;

  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp  <= 16'sd6144;
      freq <= 16'sd2048;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rsse_pkg::REG_AMPLITUDE: amp  <= cfg.data;
        rsse_pkg::REG_FREQUENCY: freq <= cfg.data;
        default: ;
      endcase
    end
    ab <= amp * freq;
  end

  // Input and squared radius
  logic               a_valid;
  logic signed [15:0] a_u;
  logic signed [15:0] a_v;
  logic               b_valid;
  logic signed [15:0] b_u;
  logic signed [15:0] b_v;
  logic [31:0]        b_r2;
  logic signed [31:0] uu;
  logic signed [31:0] vv;

  assign uu = a_u * a_u;
  assign vv = a_v * a_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= sample.valid;
      b_valid <= a_valid;
    end
    if (adv) begin
      a_u  <= sample.param_u;
      a_v  <= sample.param_v;
      b_u  <= a_u;
      b_v  <= a_v;
      b_r2 <= 32'(uu) + 32'(vv);
    end
  end

  // Square root chain
  rsse_pkg::sqrt_t sq [0:RW];
  logic [SQW-1:0]  sqs [0:RW];

  assign sq[0].valid = b_valid;
  assign sq[0].n     = {b_r2, 8'h00};
  assign sq[0].rem   = '0;
  assign sq[0].root  = '0;
  assign sqs[0]      = {b_u, b_v};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rsse_sqrt_cell #(.SIDE_W(SQW)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .din(sq[i]), .side_in(sqs[i]),
      .dout(sq[i+1]), .side_out(sqs[i+1])
    );
  end

  // Phase and a*b*u, a*b*v
  logic signed [15:0] s_u;
  logic signed [15:0] s_v;
  logic signed [36:0] theta;
  logic signed [47:0] pu;
  logic signed [47:0] pv;
  logic signed [47:0] pu_r;
  logic signed [47:0] pv_r;
  logic               c_valid;
  logic [36:0]        c_t;
  logic [CDW-1:0]     c_side;

  assign s_u   = sqs[RW][31:16];
  assign s_v   = sqs[RW][15:0];
  assign theta = 37'(freq) * 37'(signed'({1'b0, sq[RW].root}));
  assign pu    = 48'(ab) * 48'(s_u);
  assign pv    = 48'(ab) * 48'(s_v);
  assign pu_r  = pu + 48'sd32768;
  assign pv_r  = pv + 48'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= sq[RW].valid;
    end
    if (adv) begin
      c_t    <= 37'(38'(theta) + rsse_pkg::WRAP_Q28);
      c_side <= {s_u, s_v, sq[RW].root, pu_r[47:16], pv_r[47:16]};
    end
  end

  // Range reduction modulo two pi
  logic [36:0]    red   [0:NRED];
  logic           red_v [0:NRED];
  logic [CDW-1:0] red_s [0:NRED];

  assign red[0]   = c_t;
  assign red_v[0] = c_valid;
  assign red_s[0] = c_side;

  for (genvar k = 0; k < NRED; k++) begin : g_red
    localparam logic [36:0] STEP = rsse_pkg::TWO_PI_Q28 << (NRED - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        red_v[k+1] <= 1'b0;
      end else if (adv) begin
        red_v[k+1] <= red_v[k];
      end
      if (adv) begin
        red[k+1]   <= (red[k] >= STEP) ? red[k] - STEP : red[k];
        red_s[k+1] <= red_s[k];
      end
    end
  end

  // Fold into the right half plane and start the rotator
  logic signed [32:0]                ts;
  logic signed [rsse_pkg::ANG_W-1:0] z0;
  rsse_pkg::cordic_t                 cd  [0:CORDIC_STAGES];
  logic [CDW-1:0]                    cds [0:CORDIC_STAGES];

  assign ts = (red[NRED] > rsse_pkg::PI_Q28) ?
              33'(red[NRED]) - 33'(rsse_pkg::TWO_PI_Q28) : 33'(red[NRED]);
  assign z0 = {ts[31:0], 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      cd[0].valid <= 1'b0;
    end else if (adv) begin
      cd[0].valid <= red_v[NRED];
    end
    if (adv) begin
      cd[0].x <= rsse_pkg::GAIN_Q30;
      cd[0].y <= '0;
      if (z0 > rsse_pkg::HALF_PI_Q30) begin
        cd[0].z   <= z0 - rsse_pkg::PI_Q30;
        cd[0].neg <= 1'b1;
      end else if (z0 < -rsse_pkg::HALF_PI_Q30) begin
        cd[0].z   <= z0 + rsse_pkg::PI_Q30;
        cd[0].neg <= 1'b1;
      end else begin
        cd[0].z   <= z0;
        cd[0].neg <= 1'b0;
      end
      cds[0] <= red_s[NRED];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    rsse_cordic_cell #(.IDX(i), .SIDE_W(CDW)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .din(cd[i]), .side_in(cds[i]),
      .dout(cd[i+1]), .side_out(cds[i+1])
    );
  end

  // Products
  rsse_pkg::cordic_t                 cl;
  logic signed [rsse_pkg::ANG_W-1:0] sn;
  logic signed [rsse_pkg::ANG_W-1:0] cs_full;
  logic signed [31:0]                cs;
  logic signed [31:0]                l_abu;
  logic signed [31:0]                l_abv;
  logic                              e_valid;
  logic signed [49:0]                e_ps;
  logic signed [63:0]                e_pu;
  logic signed [63:0]                e_pv;
  logic signed [15:0]                e_u;
  logic signed [15:0]                e_v;
  logic [RW-1:0]                     e_r;

  assign cl      = cd[CORDIC_STAGES];
  assign sn      = cl.neg ? -cl.y : cl.y;
  assign cs_full = cl.neg ? -cl.x : cl.x;
  assign cs      = cs_full[31:0];
  assign l_abu   = cds[CORDIC_STAGES][63:32];
  assign l_abv   = cds[CORDIC_STAGES][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= cl.valid;
    end
    if (adv) begin
      e_ps <= 50'(amp) * 50'(sn);
      e_pu <= 64'(l_abu) * 64'(cs);
      e_pv <= 64'(l_abv) * 64'(cs);
      e_u  <= cds[CORDIC_STAGES][CDW-1 -: 16];
      e_v  <= cds[CORDIC_STAGES][CDW-17 -: 16];
      e_r  <= cds[CORDIC_STAGES][64 +: RW];
    end
  end

  // Round, saturate and hold the output beat
  logic signed [49:0] ps_r;
  logic signed [63:0] pu_o;
  logic signed [63:0] pv_o;
  logic signed [31:0] du_sat;
  logic signed [31:0] dv_sat;

  assign ps_r   = (e_ps + 50'sd33554432) >>> 26;
  assign pu_o   = (e_pu + 64'sd8589934592) >>> 34;
  assign pv_o   = (e_pv + 64'sd8589934592) >>> 34;
  assign du_sat = rsse_pkg::sat32(pu_o);
  assign dv_sat = rsse_pkg::sat32(pv_o);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= e_valid;
    end
    if (adv) begin
      result.pos_x    <= {{12{e_u[15]}}, e_u, 4'h0};
      result.pos_y    <= {{12{e_v[15]}}, e_v, 4'h0};
      result.pos_z    <= rsse_pkg::sat32(64'(ps_r));
      result.radius   <= 31'(e_r);
      result.du_z     <= du_sat;
      result.dv_z     <= dv_sat;
      result.normal_x <= du_sat;
      result.normal_y <= dv_sat;
    end
  end

`ifndef SYNTH
  a_stall: assert property (@(posedge clk) sample.ready == (!result.valid || result.ready))
    else $error("input ready does not follow output stall");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.radius == 31'd0) |-> (result.du_z == 32'sd0 &&
      result.dv_z == 32'sd0 && result.pos_x == 32'sd0 && result.pos_y == 32'sd0))
    else $error("nonzero slope at the origin");
  a_normal: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.normal_x == result.du_z && result.normal_y == result.dv_z))
    else $error("normal differs from tangent slope");
`endif

endmodule

// ===== dv/rsse_checker.sv =====
// Checker: watches the channels, predicts each surface point and compares every result beat.
`timescale 1ns / 100ps
module rsse_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst,
  rsse_cfg_if        cfg,
  rsse_in_if         sample,
  rsse_out_if        result,
  output int         fail_count,
  output int         pending
);

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        radius;
    logic signed [31:0] du_z;
    logic signed [31:0] dv_z;
  } point_t;

  logic signed [15:0] amp_q;
  logic signed [15:0] freq_q;
  point_t             point_q[$];
  int                 fails = 0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bit_q;
    res = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (n >= res + bit_q) begin
        n = n - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res = res >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return longint'(res);
  endfunction

  function automatic void rotate(longint theta, output longint s_o, output longint c_o);
    longint t, x, y, z, dx, dy;
    bit     neg;
    t = theta % 64'sd1686629713;
    x = 64'sd652032874;
    y = 0;
    neg = 0;
    if (t < 0) t += 64'sd1686629713;
    if (t > 64'sd843314857) t -= 64'sd1686629713;
    z = t * 4;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      neg = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      neg = 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(rsse_pkg::ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(rsse_pkg::ATAN_Q30[i]);
      end
    end
    s_o = neg ? -y : y;
    c_o = neg ? -x : x;
  endfunction

  function automatic point_t eval_point(logic signed [15:0] pu, logic signed [15:0] pv);
    point_t p;
    longint u, v, a, b, r, s, c, ab;
    u = pu;
    v = pv;
    a = amp_q;
    b = freq_q;
    r = int_root(longint'(u * u + v * v) << 8);
    rotate(b * r, s, c);
    ab = a * b;
    p.pos_x = 32'(u * 16);
    p.pos_y = 32'(v * 16);
    p.pos_z = 32'(clip32(round_sh(a * s, 26)));
    p.radius = r[30:0];
    p.du_z = 32'(clip32(round_sh(round_sh(ab * u, 16) * c, 34)));
    p.dv_z = 32'(clip32(round_sh(round_sh(ab * v, 16) * c, 34)));
    return p;
  endfunction

  task automatic cmp(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  assign pending = point_q.size();
  assign fail_count = fails;

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      amp_q <= 16'sd6144;
      freq_q <= 16'sd2048;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == rsse_pkg::REG_AMPLITUDE) amp_q <= cfg.data;
        else if (cfg.index == rsse_pkg::REG_FREQUENCY) freq_q <= cfg.data;
      end
      if (sample.valid && sample.ready) point_q.push_back(eval_point(sample.param_u, sample.param_v));
      if (result.valid && result.ready) begin
        if (point_q.size() == 0) begin
          $error("result beat with no point outstanding");
          fails++;
        end else begin
          e = point_q.pop_front();
          cmp("pos_x", e.pos_x, result.pos_x);
          cmp("pos_y", e.pos_y, result.pos_y);
          cmp("pos_z", e.pos_z, result.pos_z);
          cmp("radius", e.radius, result.radius);
          cmp("du_z", e.du_z, result.du_z);
          cmp("dv_z", e.dv_z, result.dv_z);
          cmp("normal_x", e.du_z, result.normal_x);
          cmp("normal_y", e.dv_z, result.normal_y);
        end
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Testbench top: drives parameter points and register writes, then reports the verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int STAGES   = 16;
  localparam int LATENCY  = 31 + STAGES;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;
  int   in_gap;
  int   out_gap;

  rsse_cfg_if cfg();
  rsse_in_if  sample();
  rsse_out_if result();

  radial_sine_surface_eval #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst), .cfg(cfg), .sample(sample), .result(result)
  );

  rsse_checker #(.CORDIC_STAGES(STAGES)) chk (
    .clk(clk), .rst(rst), .cfg(cfg), .sample(sample), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      result.ready <= 1'b1;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      result.ready <= (out_gap == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 12);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample.valid && sample.ready) || (result.valid && result.ready)
                 || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_point(logic signed [15:0] pu, logic signed [15:0] pv);
    if (!calm && in_gap == 0 && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 12);
    while (in_gap > 0) begin
      sample.valid <= 1'b0;
      @(posedge clk);
      in_gap--;
    end
    sample.valid <= 1'b1;
    sample.param_u <= pu;
    sample.param_v <= pv;
    do @(posedge clk); while (!sample.ready);
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(rsse_pkg::reg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_points(int n);
    logic signed [15:0] pu, pv;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin pu = 16'($urandom); pv = 16'($urandom); end
        1: begin
          pu = 16'($urandom_range(0, 8191) - 4096);
          pv = 16'($urandom_range(0, 8191) - 4096);
        end
        2: begin pu = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000; pv = 16'($urandom); end
        default: begin
          pu = 16'($urandom_range(0, 63) - 32);
          pv = 16'($urandom_range(0, 63) - 32);
        end
      endcase
      send_point(pu, pv);
    end
  endtask

  initial begin
    logic signed [15:0] corner[6] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001,
                                       16'shffff, 16'sh1000};
    rst = 1'b1;
    calm = 0;
    in_gap = 0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    sample.valid = 1'b0;
    sample.param_u = '0;
    sample.param_v = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 6; i++) begin
      send_point(corner[i], corner[(i + 2) % 6]);
      send_point(corner[i], corner[i]);
    end
    drain();

    write_reg(rsse_pkg::REG_AMPLITUDE, 16'h7fff);
    write_reg(rsse_pkg::REG_FREQUENCY, 16'h7fff);
    write_reg(rsse_pkg::reg_idx_t'(8'd7), 16'h1234);
    for (int i = 0; i < 6; i++) send_point(corner[i], corner[5 - i]);
    random_points(150);
    drain();

    write_reg(rsse_pkg::REG_AMPLITUDE, 16'h8000);
    write_reg(rsse_pkg::REG_FREQUENCY, 16'h8000);
    random_points(150);
    drain();

    write_reg(rsse_pkg::REG_AMPLITUDE, 16'($urandom));
    write_reg(rsse_pkg::REG_FREQUENCY, 16'($urandom));
    random_points(150);
    drain();

    write_reg(rsse_pkg::REG_AMPLITUDE, 16'h0000);
    write_reg(rsse_pkg::REG_FREQUENCY, 16'($urandom_range(0, 16383)));
    random_points(60);
    calm = 1;
    random_points(80);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rsse_pkg.sv
src/rsse_in_if.sv
src/rsse_out_if.sv
src/rsse_cfg_if.sv
src/rsse_sqrt_cell.sv
src/rsse_cordic_cell.sv
src/radial_sine_surface_eval.sv
dv/rsse_checker.sv
dv/testbench.sv
